FILE: sv/rhc_pkg.sv
// rgb to hsv converter shared types and constants
`timescale 1ns / 1ps

package rhc_pkg;

	typedef enum logic [1:0] {
		SECT_RED   = 2'd0,
		SECT_GREEN = 2'd1,
		SECT_BLUE  = 2'd2
	} sector_t;

	localparam int unsigned SIX_SPAN_EXTRA_BITS = 3;

endpackage

FILE: sv/rhc_if.sv
// valid/ready channels for rgb pixel words and hsv result words
`timescale 1ns / 1ps

interface rgb_word_if #(
	parameter int unsigned CW = 8
);
	logic          valid;
	logic          ready;
	logic [CW-1:0] red;
	logic [CW-1:0] green;
	logic [CW-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface hsv_word_if #(
	parameter int unsigned CW = 8,
	parameter int unsigned FW = 16
);
	logic          valid;
	logic          ready;
	logic [FW-1:0] hue;
	logic [FW-1:0] saturation;
	logic [CW-1:0] brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

FILE: sv/rhc_prep.sv
// front stages: max/min and sector pick, then span, hue position and hue divisor
`timescale 1ns / 1ps

module rhc_prep #(
	parameter int unsigned CW = 8,
	parameter int unsigned PW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [CW-1:0] red,
	input  logic [CW-1:0] green,
	input  logic [CW-1:0] blue,
	output logic          out_valid,
	output logic [CW-1:0] hi,
	output logic [CW-1:0] span,
	output logic [PW-1:0] pos,
	output logic [PW-1:0] six_span,
	output logic          grey,
	output logic          black
);
	import rhc_pkg::*;

	logic          valid_s1;
	logic [CW-1:0] red_s1, green_s1, blue_s1, hi_s1, lo_s1;
	sector_t       sector_s1;

	logic          valid_s2;
	logic [CW-1:0] hi_s2, span_s2;
	logic [PW-1:0] pos_s2, six_span_s2;
	logic          grey_s2, black_s2;

	sector_t       sector_c;
	logic [CW-1:0] hi_c, lo_c, span_c;
	logic [PW-1:0] span_w, six_c, base_c, add_c, sub_c;

	// sector: ties go to red, then green
	always_comb begin
		priority if (red >= green && red >= blue) begin
			sector_c = SECT_RED;
			hi_c = red;
		end else if (green >= blue) begin
			sector_c = SECT_GREEN;
			hi_c = green;
		end else begin
			sector_c = SECT_BLUE;
			hi_c = blue;
		end
		lo_c = red;
		if (green < lo_c) lo_c = green;
		if (blue < lo_c) lo_c = blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1    <= red;
			green_s1  <= green;
			blue_s1   <= blue;
			hi_s1     <= hi_c;
			lo_s1     <= lo_c;
			sector_s1 <= sector_c;
		end
	end

	// position within the turn in units of span, kept in [0, 6*span)
	always_comb begin
		span_c = hi_s1 - lo_s1;
		span_w = PW'(span_c);
		six_c  = (span_w << 2) + (span_w << 1);
		unique case (sector_s1)
			SECT_RED: begin
				base_c = (green_s1 >= blue_s1) ? '0 : six_c;
				add_c  = PW'(green_s1);
				sub_c  = PW'(blue_s1);
			end
			SECT_GREEN: begin
				base_c = span_w << 1;
				add_c  = PW'(blue_s1);
				sub_c  = PW'(red_s1);
			end
			SECT_BLUE: begin
				base_c = span_w << 2;
				add_c  = PW'(red_s1);
				sub_c  = PW'(green_s1);
			end
			default: begin
				base_c = '0;
				add_c  = '0;
				sub_c  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s2       <= hi_s1;
			span_s2     <= span_c;
			pos_s2      <= base_c + add_c - sub_c;
			six_span_s2 <= six_c;
			grey_s2     <= (span_c == '0);
			black_s2    <= (hi_s1 == '0);
		end
	end

	assign out_valid = valid_s2;
	assign hi        = hi_s2;
	assign span      = span_s2;
	assign pos       = pos_s2;
	assign six_span  = six_span_s2;
	assign grey      = grey_s2;
	assign black     = black_s2;

endmodule

FILE: sv/rhc_div.sv
// pipelined restoring divider, one quotient bit per stage, num below twice den
`timescale 1ns / 1ps

module rhc_div #(
	parameter int unsigned DEN_W  = 8,
	parameter int unsigned QUO_W  = 17,
	parameter int unsigned SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DEN_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);
	logic              valid_sk [QUO_W+1];
	logic [DEN_W-1:0]  rem_sk   [QUO_W+1];
	logic [DEN_W-1:0]  den_sk   [QUO_W+1];
	logic [QUO_W-1:0]  quo_sk   [QUO_W+1];
	logic [SIDE_W-1:0] side_sk  [QUO_W+1];

	assign valid_sk[0] = in_valid;
	assign rem_sk[0]   = num;
	assign den_sk[0]   = den;
	assign quo_sk[0]   = '0;
	assign side_sk[0]  = side_in;

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [DEN_W:0] x_c;
		logic [DEN_W:0] diff_c;
		logic           ge_c;

		// integer bit first, then one fraction bit per stage
		if (k == 0) begin : g_first
			assign x_c = {1'b0, rem_sk[k]};
		end else begin : g_next
			assign x_c = {rem_sk[k], 1'b0};
		end

		assign diff_c = x_c - {1'b0, den_sk[k]};
		assign ge_c   = (x_c >= {1'b0, den_sk[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sk[k+1] <= 1'b0;
			end else if (en) begin
				valid_sk[k+1] <= valid_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k+1]  <= ge_c ? diff_c[DEN_W-1:0] : x_c[DEN_W-1:0];
				den_sk[k+1]  <= den_sk[k];
				quo_sk[k+1]  <= {quo_sk[k][QUO_W-2:0], ge_c};
				side_sk[k+1] <= side_sk[k];
			end
		end
	end

	assign out_valid = valid_sk[QUO_W];
	assign quo       = quo_sk[QUO_W];
	assign side_out  = side_sk[QUO_W];

endmodule

FILE: sv/rgb_to_hsv_convert.sv
// pixel words pass the prep stages, divider stages, then the output register
// throughput: one pixel per cycle when not stalled, one quotient bit per stage
// a stalled output word holds the whole pipeline; bubbles are not squeezed out
// reset: arst_n clears all valid bits asynchronously, payload is not reset
// top level: rgb to hsv pixel converter
`timescale 1ns / 1ps

module rgb_to_hsv_convert #(
	parameter int unsigned CHANNEL_BITS  = 8,
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	rgb_word_if.sink   px_in,
	hsv_word_if.source px_out
);
	import rhc_pkg::*;

	localparam int unsigned CW = CHANNEL_BITS;
	localparam int unsigned FW = FRACTION_BITS;
	localparam int unsigned PW = CW + SIX_SPAN_EXTRA_BITS;
	localparam int unsigned QW = FW + 1;

	logic          en;
	logic          prep_valid;
	logic [CW-1:0] prep_hi, prep_span;
	logic [PW-1:0] prep_pos, prep_six;
	logic          prep_grey, prep_black;

	logic          sat_valid, hue_valid;
	logic [QW-1:0] sat_quo, hue_quo;
	logic          sat_black;
	logic [CW:0]   hue_side;

	logic          valid_q;
	logic [FW-1:0] hue_q, sat_q;
	logic [CW-1:0] bright_q;

	assign en          = !valid_q || px_out.ready;
	assign px_in.ready = en;

	rhc_prep #(
		.CW (CW),
		.PW (PW)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (px_in.valid),
		.red       (px_in.red),
		.green     (px_in.green),
		.blue      (px_in.blue),
		.out_valid (prep_valid),
		.hi        (prep_hi),
		.span      (prep_span),
		.pos       (prep_pos),
		.six_span  (prep_six),
		.grey      (prep_grey),
		.black     (prep_black)
	);

	rhc_div #(
		.DEN_W  (CW),
		.QUO_W  (QW),
		.SIDE_W (1)
	) u_sat_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prep_valid),
		.num       (prep_span),
		.den       (prep_hi),
		.side_in   (prep_black),
		.out_valid (sat_valid),
		.quo       (sat_quo),
		.side_out  (sat_black)
	);

	rhc_div #(
		.DEN_W  (PW),
		.QUO_W  (QW),
		.SIDE_W (CW + 1)
	) u_hue_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prep_valid),
		.num       (prep_pos),
		.den       (prep_six),
		.side_in   ({prep_grey, prep_hi}),
		.out_valid (hue_valid),
		.quo       (hue_quo),
		.side_out  (hue_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= hue_valid;
		end
	end

	// grey gives hue zero, black gives saturation zero, full span saturates
	always_ff @(posedge clk) begin
		if (en) begin
			hue_q    <= hue_side[CW] ? '0 : hue_quo[FW-1:0];
			sat_q    <= sat_black ? '0 : (sat_quo[FW] ? '1 : sat_quo[FW-1:0]);
			bright_q <= hue_side[CW-1:0];
		end
	end

	assign px_out.valid      = valid_q;
	assign px_out.hue        = hue_q;
	assign px_out.saturation = sat_q;
	assign px_out.brightness = bright_q;

`ifndef ASSERT_OFF
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		sat_valid == hue_valid)
		else $error("divider lanes out of step");

	a_black_word: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && bright_q == '0 |-> hue_q == '0 && sat_q == '0)
		else $error("black word with nonzero hue or saturation");

	a_hue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		hue_valid && !hue_side[CW] |-> !hue_quo[FW])
		else $error("hue quotient reached one turn");
`endif

endmodule

FILE: verif/rgb_to_hsv_convert_test.sv
// self-checking testbench for the rgb to hsv pixel converter
`timescale 1ns / 1ps

module rgb_to_hsv_convert_test;

	import rhc_pkg::*;

	localparam int unsigned CB = 8;
	localparam int unsigned FB = 16;
	localparam int unsigned PIPE_CYCLES = FB + 4;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_PER_PHASE = 250;

	typedef struct packed {
		logic [CB-1:0] red;
		logic [CB-1:0] green;
		logic [CB-1:0] blue;
	} rgb_word_t;

	typedef struct packed {
		logic [FB-1:0] hue;
		logic [FB-1:0] saturation;
		logic [CB-1:0] brightness;
	} hsv_word_t;

	class hsv_scoreboard;
		hsv_word_t pending[$];
		int unsigned errors;

		function hsv_word_t predict_hsv(rgb_word_t px);
			int unsigned r, g, b, hi, lo, span, sat, pos;
			sector_t sect;
			hsv_word_t w;
			r = 32'(px.red);
			g = 32'(px.green);
			b = 32'(px.blue);
			hi = r;
			sect = SECT_RED;
			if (g > hi) begin
				hi = g;
				sect = SECT_GREEN;
			end
			if (b > hi) begin
				hi = b;
				sect = SECT_BLUE;
			end
			lo = r;
			if (g < lo) lo = g;
			if (b < lo) lo = b;
			span = hi - lo;
			sat = 0;
			if (hi != 0) begin
				sat = (span << FB) / hi;
				if (sat > (1 << FB) - 1) sat = (1 << FB) - 1;
			end
			pos = 0;
			if (span != 0) begin
				case (sect)
					SECT_RED: pos = (g >= b) ? g - b : 6 * span + g - b;
					SECT_GREEN: pos = 2 * span + b - r;
					default: pos = 4 * span + r - g;
				endcase
				pos = (pos << FB) / (6 * span);
			end
			w.hue = pos[FB-1:0];
			w.saturation = sat[FB-1:0];
			w.brightness = hi[CB-1:0];
			return w;
		endfunction

		function void note_pixel(rgb_word_t px);
			pending.insert(pending.size(), predict_hsv(px));
		endfunction

		function void check_word(hsv_word_t got);
			hsv_word_t want;
			if (pending.size() == 0) begin
				$error("result word with no pixel pending: hue %0d saturation %0d brightness %0d",
					got.hue, got.saturation, got.brightness);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.hue !== want.hue) begin
				$error("hue expected %0d actual %0d", want.hue, got.hue);
				errors++;
			end
			if (got.saturation !== want.saturation) begin
				$error("saturation expected %0d actual %0d", want.saturation, got.saturation);
				errors++;
			end
			if (got.brightness !== want.brightness) begin
				$error("brightness expected %0d actual %0d", want.brightness, got.brightness);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rgb_word_if #(.CW(CB)) px ();
	hsv_word_if #(.CW(CB), .FW(FB)) hv ();

	rgb_to_hsv_convert #(
		.CHANNEL_BITS(CB),
		.FRACTION_BITS(FB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.px_in(px.sink),
		.px_out(hv.source)
	);

	hsv_scoreboard sb = new;
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	int unsigned hold_tag = 0;
	int unsigned hold_seen = 0;
	int unsigned quiet_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: random ready with one long hold-off on request
	initial begin
		hv.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_tag != hold_seen) begin
				hold_seen = hold_tag;
				hv.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			hv.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (px.valid && px.ready)
			sb.note_pixel('{red: px.red, green: px.green, blue: px.blue});
		if (hv.valid && hv.ready)
			sb.check_word('{hue: hv.hue, saturation: hv.saturation, brightness: hv.brightness});
		if ((px.valid && px.ready) || (hv.valid && hv.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("rgb_to_hsv_convert verification failed");
			$finish;
		end
	end

	task automatic send_pixel(input rgb_word_t w);
		while ($urandom_range(99) < send_idle) begin
			px.valid <= 1'b0;
			@(posedge clk);
		end
		px.valid <= 1'b1;
		px.red <= w.red;
		px.green <= w.green;
		px.blue <= w.blue;
		do @(posedge clk); while (!px.ready);
	endtask

	function automatic rgb_word_t random_pixel();
		rgb_word_t p;
		p.red = CB'($urandom_range(255));
		p.green = CB'($urandom_range(255));
		p.blue = CB'($urandom_range(255));
		case ($urandom_range(9))
			0: begin
				p.green = p.red;
				p.blue = p.red;
			end
			1: p.green = p.red;
			2: p.blue = p.green;
			3: p.blue = p.red;
			4: p.blue = $urandom_range(1) ? 8'd255 : 8'd0;
			5: p.red = $urandom_range(1) ? 8'd255 : 8'd0;
			default: ;
		endcase
		return p;
	endfunction

	task automatic send_random(input int unsigned count);
		repeat (count) send_pixel(random_pixel());
	endtask

	initial begin
		rgb_word_t directed[$];
		px.valid <= 1'b0;
		px.red <= '0;
		px.green <= '0;
		px.blue <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// black, white, greys, primaries, ties, wrap of red sector, narrow spans
		directed = '{
			'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
			'{8'd1, 8'd1, 8'd1}, '{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0},
			'{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd255},
			'{8'd255, 8'd0, 8'd255}, '{8'd255, 8'd0, 8'd10}, '{8'd200, 8'd10, 8'd199},
			'{8'd1, 8'd0, 8'd0}, '{8'd0, 8'd1, 8'd0}, '{8'd0, 8'd0, 8'd1},
			'{8'd255, 8'd254, 8'd254}, '{8'd254, 8'd255, 8'd253}, '{8'd100, 8'd200, 8'd50},
			'{8'd50, 8'd100, 8'd200}, '{8'd200, 8'd50, 8'd100}, '{8'd30, 8'd20, 8'd10},
			'{8'd170, 8'd85, 8'd170}
		};

		send_idle = 28;
		recv_idle <= 51;
		foreach (directed[i]) send_pixel(directed[i]);
		send_random(RANDOM_PER_PHASE);

		send_idle = 51;
		recv_idle <= 28;
		send_random(RANDOM_PER_PHASE);

		send_idle = 0;
		recv_idle <= 0;
		hold_tag <= hold_tag + 1;
		send_random(RANDOM_PER_PHASE);
		px.valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (PIPE_CYCLES + 8) @(posedge clk);

		if (sb.pending.size() != 0) begin
			$error("%0d result words never arrived", sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("rgb_to_hsv_convert verification clean");
		else
			$display("rgb_to_hsv_convert verification failed");
		$finish;
	end

endmodule
